// ===== hw/rtl/tet_pkg.sv =====
// ----------------------------------------------------------------------------
// Timed event table package
// Shared sizes, entry record, operation codes and the saturating time add.
// ----------------------------------------------------------------------------
package tet_pkg;

   localparam int ENTRIES    = 16;
   localparam int MAX_RES    = 16;
   localparam int TIME_W     = 32;
   localparam int ID_W       = 32;
   localparam int STEP_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int FCNT_W     = $clog2(MAX_RES + 1);
   localparam int REQ_DATA_W = 3 * TIME_W;
   localparam int RSP_USED_W = 1 + ID_W + ID_W + TIME_W + 1;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   typedef enum logic [1:0] {
      OP_ADD_REPEAT = 2'd0,
      OP_ADD_ONCE   = 2'd1,
      OP_CANCEL     = 2'd2,
      OP_TICK       = 2'd3
   } op_type;

   typedef struct packed {
      logic              used;
      logic              mark;      // fired in this tick, result still owed
      logic              repeats;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] period;
   } entry_type;

   typedef struct packed {
      logic   emit;
      op_type op;
      logic   fire_ok;
   } proc_ctrl_type;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/tet_cell.sv =====
// ----------------------------------------------------------------------------
// Timed event table cell
// One entry of the ring; loads its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module tet_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  tet_pkg::entry_type entry_in,
   output tet_pkg::entry_type entry_out
);
   import tet_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.used <= 1'b0;
         entry_ff.mark <= 1'b0;
      end else if (shift) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

// ===== hw/rtl/tet_proc.sv =====
// ----------------------------------------------------------------------------
// Timed event table entry processor
// Sits between the head and the tail of the ring and applies the current
// request to each entry as it goes by.
// ----------------------------------------------------------------------------
module tet_proc (
   input  tet_pkg::proc_ctrl_type          ctrl,
   input  logic [tet_pkg::TIME_W-1:0]      now,
   input  logic [tet_pkg::TIME_W-1:0]      base,
   input  logic [tet_pkg::ID_W-1:0]        cancel_id,
   input  tet_pkg::entry_type              head,
   input  tet_pkg::entry_type              carry,
   input  logic                            carry_valid,
   output tet_pkg::entry_type              tail,
   output tet_pkg::entry_type              carry_next,
   output logic                            carry_valid_next,
   output logic                            fire
);
   import tet_pkg::*;

   always_comb begin
      tail             = head;
      carry_next       = carry;
      carry_valid_next = carry_valid;
      fire             = 1'b0;
      if (ctrl.emit) begin
         tail.mark = 1'b0;
      end else begin
         case (ctrl.op)
            OP_ADD_REPEAT, OP_ADD_ONCE: begin
               // new entry goes in front; older ones slide back until a hole
               if (carry_valid) begin
                  tail = carry;
                  if (head.used) begin
                     carry_next = head;
                  end else begin
                     carry_valid_next = 1'b0;
                  end
               end
            end
            OP_CANCEL: begin
               if (head.used && head.id == cancel_id) begin
                  tail.used = 1'b0;
               end
            end
            OP_TICK: begin
               if (head.used && head.deadline <= now && ctrl.fire_ok) begin
                  fire      = 1'b1;
                  tail.mark = 1'b1;
                  if (head.repeats) begin
                     tail.deadline = sat_add(base, head.period);
                  end else begin
                     tail.used = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/timed_event_table_unit.sv =====
// ----------------------------------------------------------------------------
// Timed event table unit
// Holds timed events in a ring of cells kept newest first; adds, cancels
// and fires them and reports the earliest pending deadline.
// ----------------------------------------------------------------------------
// One request at a time. Every request rotates the ring of ENTRIES cells once
// through the entry processor, then gives its result. A tick that fires adds a
// second rotation that hands out the fired ids newest first, and that rotation
// waits while the result side stalls.
// After reset the table is empty and ready at once.
module timed_event_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tet_pkg::REQ_DATA_W-1:0]    req_tdata,  // now, interval, cancel_id
   input  logic [1:0]                        req_tuser,  // op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tet_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // status, new_id, fired_id,
                                                         // next_deadline, next_valid
   output logic                              rsp_tuser,  // fired
   output logic                              rsp_tlast   // last
);
   import tet_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_EMIT = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [ID_W-1:0]   cancel_id_ff, cancel_id_in;
   entry_type         carry_ff, carry_in;
   logic              carry_valid_ff, carry_valid_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [FCNT_W-1:0] fcnt_ff, fcnt_in;
   logic [CNT_W-1:0]  cnt_acc_ff, cnt_acc_in;
   logic [TIME_W-1:0] min_ff, min_in;
   logic              min_valid_ff, min_valid_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] earliest_ff, earliest_in;
   logic              earliest_valid_ff, earliest_valid_in;
   logic [ID_W-1:0]   id_counter_ff, id_counter_in;
   logic              status_ff, status_in;
   logic [ID_W-1:0]   new_id_ff, new_id_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]   rsp_new_id_ff, rsp_new_id_in;
   logic              rsp_fired_ff, rsp_fired_in;
   logic [ID_W-1:0]   rsp_fired_id_ff, rsp_fired_id_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [TIME_W-1:0] rsp_deadline_ff, rsp_deadline_in;
   logic              rsp_next_valid_ff, rsp_next_valid_in;

   entry_type         cell_q [ENTRIES];
   entry_type         head, tail, carry_next;
   logic              carry_valid_next, fire;
   proc_ctrl_type     ctrl;
   logic              shift, step_last, out_free, req_accept;

   op_type            r_op;
   logic [TIME_W-1:0] r_now, r_interval;
   logic [ID_W-1:0]   r_cancel_id;
   logic              r_add, full;

   logic              scan_take, scan_min_valid;
   logic [TIME_W-1:0] scan_min;
   logic [CNT_W-1:0]  scan_cnt;
   logic [FCNT_W-1:0] scan_fcnt;

   // ring: cell 0 is the head (newest), the processor feeds the last cell
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type next_entry;
      if (i == ENTRIES - 1) begin : g_tail
         assign next_entry = tail;
      end else begin : g_link
         assign next_entry = cell_q[i+1];
      end
      tet_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .entry_in  (next_entry),
         .entry_out (cell_q[i])
      );
   end

   assign head         = cell_q[0];
   assign ctrl.emit    = (state_ff == S_EMIT);
   assign ctrl.op      = op_ff;
   assign ctrl.fire_ok = (fcnt_ff < FCNT_W'(MAX_RES));

   tet_proc u_proc (
      .ctrl             (ctrl),
      .now              (now_ff),
      .base             (earliest_ff),
      .cancel_id        (cancel_id_ff),
      .head             (head),
      .carry            (carry_ff),
      .carry_valid      (carry_valid_ff),
      .tail             (tail),
      .carry_next       (carry_next),
      .carry_valid_next (carry_valid_next),
      .fire             (fire)
   );

   assign r_now       = req_tdata[TIME_W-1:0];
   assign r_interval  = req_tdata[2*TIME_W-1:TIME_W];
   assign r_cancel_id = req_tdata[2*TIME_W+ID_W-1:2*TIME_W];
   assign r_op        = op_type'(req_tuser);
   assign r_add       = (r_op == OP_ADD_REPEAT) || (r_op == OP_ADD_ONCE);
   assign full        = (count_ff == CNT_W'(ENTRIES));

   assign req_tready  = (state_ff == S_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign step_last   = (step_ff == STEP_W'(ENTRIES - 1));
   assign shift       = (state_ff == S_SCAN) ||
                        ((state_ff == S_EMIT) && (!head.mark || out_free));

   // running minimum and fill count over the entries written back
   assign scan_take      = tail.used && (!min_valid_ff || tail.deadline < min_ff);
   assign scan_min       = scan_take ? tail.deadline : min_ff;
   assign scan_min_valid = min_valid_ff || tail.used;
   assign scan_cnt       = cnt_acc_ff + CNT_W'(tail.used);
   assign scan_fcnt      = fcnt_ff + FCNT_W'(fire);

   always_comb begin
      state_in          = state_ff;
      op_in             = op_ff;
      now_in            = now_ff;
      cancel_id_in      = cancel_id_ff;
      carry_in          = carry_ff;
      carry_valid_in    = carry_valid_ff;
      step_in           = step_ff;
      fcnt_in           = fcnt_ff;
      cnt_acc_in        = cnt_acc_ff;
      min_in            = min_ff;
      min_valid_in      = min_valid_ff;
      count_in          = count_ff;
      earliest_in       = earliest_ff;
      earliest_valid_in = earliest_valid_ff;
      id_counter_in     = id_counter_ff;
      status_in         = status_ff;
      new_id_in         = new_id_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_status_in     = rsp_status_ff;
      rsp_new_id_in     = rsp_new_id_ff;
      rsp_fired_in      = rsp_fired_ff;
      rsp_fired_id_in   = rsp_fired_id_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_deadline_in   = rsp_deadline_ff;
      rsp_next_valid_in = rsp_next_valid_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in            = r_op;
               now_in           = r_now;
               cancel_id_in     = r_cancel_id;
               carry_in.used     = 1'b1;
               carry_in.mark     = 1'b0;
               carry_in.repeats  = (r_op == OP_ADD_REPEAT);
               carry_in.id       = id_counter_ff;
               carry_in.deadline = sat_add(r_now, r_interval);
               carry_in.period   = r_interval;
               carry_valid_in   = r_add && !full;
               status_in        = r_add && full;
               new_id_in        = (r_add && !full) ? id_counter_ff : '0;
               if (r_add && !full) begin
                  id_counter_in = id_counter_ff + ID_W'(1);
               end
               step_in      = '0;
               fcnt_in      = '0;
               cnt_acc_in   = '0;
               min_in       = '0;
               min_valid_in = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            carry_in       = carry_next;
            carry_valid_in = carry_valid_next;
            fcnt_in        = scan_fcnt;
            cnt_acc_in     = scan_cnt;
            min_in         = scan_min;
            min_valid_in   = scan_min_valid;
            step_in        = step_ff + STEP_W'(1);
            if (step_last) begin
               step_in           = '0;
               count_in          = scan_cnt;
               earliest_in       = scan_min;
               earliest_valid_in = scan_min_valid;
               state_in          = (scan_fcnt != '0) ? S_EMIT : S_DONE;
            end
         end
         S_EMIT: begin
            if (shift) begin
               step_in = step_ff + STEP_W'(1);
               if (head.mark) begin
                  rsp_valid_in      = 1'b1;
                  rsp_status_in     = status_ff;
                  rsp_new_id_in     = new_id_ff;
                  rsp_fired_in      = 1'b1;
                  rsp_fired_id_in   = head.id;
                  rsp_last_in       = (fcnt_ff == FCNT_W'(1));
                  rsp_deadline_in   = earliest_ff;
                  rsp_next_valid_in = earliest_valid_ff;
                  fcnt_in           = fcnt_ff - FCNT_W'(1);
               end
               if (step_last) begin
                  step_in  = '0;
                  state_in = S_IDLE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_new_id_in     = new_id_ff;
               rsp_fired_in      = 1'b0;
               rsp_fired_id_in   = '0;
               rsp_last_in       = 1'b1;
               rsp_deadline_in   = earliest_ff;
               rsp_next_valid_in = earliest_valid_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         carry_valid_ff    <= 1'b0;
         step_ff           <= '0;
         fcnt_ff           <= '0;
         count_ff          <= '0;
         earliest_ff       <= '0;
         earliest_valid_ff <= 1'b0;
         id_counter_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         carry_valid_ff    <= carry_valid_in;
         step_ff           <= step_in;
         fcnt_ff           <= fcnt_in;
         count_ff          <= count_in;
         earliest_ff       <= earliest_in;
         earliest_valid_ff <= earliest_valid_in;
         id_counter_ff     <= id_counter_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      op_ff             <= op_in;
      now_ff            <= now_in;
      cancel_id_ff      <= cancel_id_in;
      carry_ff          <= carry_in;
      cnt_acc_ff        <= cnt_acc_in;
      min_ff            <= min_in;
      min_valid_ff      <= min_valid_in;
      status_ff         <= status_in;
      new_id_ff         <= new_id_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_new_id_ff     <= rsp_new_id_in;
      rsp_fired_ff      <= rsp_fired_in;
      rsp_fired_id_ff   <= rsp_fired_id_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_deadline_ff   <= rsp_deadline_in;
      rsp_next_valid_ff <= rsp_next_valid_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_next_valid_ff, rsp_deadline_ff,
                        rsp_fired_id_ff, rsp_new_id_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_fired_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count beyond table size");

   a_earliest_matches_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (earliest_valid_ff == (count_ff != '0)))
      else $error("earliest valid flag disagrees with fill count");

   a_emit_drains: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EMIT) && shift && step_last) |-> (fcnt_in == '0))
      else $error("fired results left over at end of emit pass");

   a_empty_deadline_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_next_valid_ff || rsp_deadline_ff == '0))
      else $error("nonzero deadline reported for empty table");

endmodule
